@@ rtl/postfix_expression_evaluator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PEE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/pee_pkg.sv @@
// ----------------------------------------------------------------------------
// pee_pkg
// Shared constants and command types for the postfix evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package pee_pkg;
    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_MUL   = 8'h2A;
    localparam logic [7:0] C_DIV   = 8'h2F;
    localparam logic [7:0] C_POW   = 8'h24;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } t_op;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       ld_sym;    // latch the incoming transaction
        logic       rd_top;    // start a stack read at count-1
        logic       pop;       // take the read data as an operand
        logic       sel_rhs;   // the popped operand is the right one
        logic       push_dig;  // push the digit value
        logic       push_res;  // push the arithmetic result
        logic       start;     // start the arithmetic unit
        logic       flag_bad;  // record an unknown character
        logic       emit;      // load output register from the final pop
        logic       clear;     // clear the stack and flags
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic       is_digit;
        logic       is_op;
        logic       last;
        logic       alu_done;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/pee_alu.sv @@
// ----------------------------------------------------------------------------
// pee_alu
// Multi-cycle arithmetic unit: add, sub, direct multiply, restoring divide,
// square-and-multiply power with one 32x32 multiply per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_alu import pee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_op         i_op,
    input  wire logic [31:0] i_lhs,
    input  wire logic [31:0] i_rhs,
    output logic             o_done,
    output logic [31:0]      o_res,
    output logic             o_div0
);
    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_DIV  = 5'b00010,
        A_POWR = 5'b00100,
        A_POWB = 5'b01000,
        A_DONE = 5'b10000
    } t_ast;

    t_ast        r_st, n_st;
    logic [31:0] r_a, n_a;       // dividend shift / base
    logic [31:0] r_b, n_b;       // divisor / exponent
    logic [31:0] r_q, n_q;       // quotient / result
    logic [31:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic        r_z, n_z;
    logic [32:0] s_trial;
    logic [31:0] s_prod;
    logic [31:0] s_mag_l, s_mag_r;

    assign s_mag_l = i_lhs[31] ? (32'd0 - i_lhs) : i_lhs;
    assign s_mag_r = i_rhs[31] ? (32'd0 - i_rhs) : i_rhs;
    assign s_trial = {r_rem, r_a[31]} - {1'b0, r_b};
    assign s_prod  = (r_st == A_POWR) ? (r_q * r_a) : (r_a * r_a);

    always_comb begin
        n_st = r_st; n_a = r_a; n_b = r_b; n_q = r_q; n_rem = r_rem;
        n_cnt = r_cnt; n_neg = r_neg; n_z = r_z;
        unique case (r_st)
            A_IDLE: begin
                if (i_start) begin
                    n_z = 1'b0;
                    n_st = A_DONE;
                    unique case (i_op)
                        OP_ADD: n_q = i_lhs + i_rhs;
                        OP_SUB: n_q = i_lhs - i_rhs;
                        OP_MUL: n_q = i_lhs * i_rhs;
                        OP_DIV: begin
                            if (i_rhs == 32'd0) begin
                                n_q = 32'd0;
                                n_z = 1'b1;
                            end else begin
                                n_a = s_mag_l; n_b = s_mag_r; n_rem = 32'd0;
                                n_q = 32'd0; n_cnt = 6'd32;
                                n_neg = i_lhs[31] ^ i_rhs[31];
                                n_st = A_DIV;
                            end
                        end
                        OP_POW: begin
                            if (i_rhs[31]) begin
                                if (i_lhs == 32'd1) n_q = 32'd1;
                                else if (i_lhs == 32'hFFFF_FFFF)
                                    n_q = i_rhs[0] ? 32'hFFFF_FFFF : 32'd1;
                                else n_q = 32'd0;
                            end else begin
                                n_a = i_lhs; n_b = i_rhs; n_q = 32'd1;
                                n_st = A_POWR;
                            end
                        end
                        default: n_q = 32'd0;
                    endcase
                end
            end
            A_DIV: begin
                if (!s_trial[32]) begin
                    n_rem = s_trial[31:0];
                    n_q   = {r_q[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[30:0], r_a[31]};
                    n_q   = {r_q[30:0], 1'b0};
                end
                n_a = {r_a[30:0], 1'b0};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    if (r_neg) n_q = 32'd0 - n_q;
                    n_st = A_DONE;
                end
            end
            A_POWR: begin
                if (r_b == 32'd0) n_st = A_DONE;
                else begin
                    if (r_b[0]) n_q = s_prod;
                    n_st = A_POWB;
                end
            end
            A_POWB: begin
                n_a = s_prod;
                n_b = {1'b0, r_b[31:1]};
                n_st = A_POWR;
            end
            A_DONE: n_st = A_IDLE;
            default: n_st = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_a <= n_a; r_b <= n_b; r_q <= n_q; r_rem <= n_rem;
        r_cnt <= n_cnt; r_neg <= n_neg; r_z <= n_z;
    end

    assign o_done = (r_st == A_DONE);
    assign o_res  = r_q;
    assign o_div0 = r_z;
endmodule
`default_nettype wire

@@ rtl/pee_datapath.sv @@
// ----------------------------------------------------------------------------
// pee_datapath
// Symbol register, operand stack memory, flags, ALU and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_datapath import pee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_final_symbol,
    output logic [31:0]      o_value,
    output logic [3:0]       o_flags
);
    logic [31:0] r_mem [STACK_DEPTH];
    logic [31:0] r_rd;
    logic        r_rd_ok;      // read hit a non-empty stack
    logic [CNT_W-1:0] r_cnt;
    logic [3:0]  r_flags;      // under, over, div0, bad
    logic [7:0]  r_sym;
    logic        r_last;
    logic [31:0] r_lhs, r_rhs;
    logic [31:0] s_pop;
    logic [31:0] s_wdata;
    logic        s_push, s_full;
    logic        s_done, s_div0;
    logic [31:0] s_res;
    t_op         s_op;

    assign s_pop  = r_rd_ok ? r_rd : 32'd0;
    assign s_full = (r_cnt == CNT_W'(STACK_DEPTH));
    assign s_push = i_cmd.push_dig | i_cmd.push_res;
    assign s_wdata = i_cmd.push_dig ? 32'(r_sym - C_ZERO) : s_res;

    always_comb begin
        unique case (r_sym)
            C_PLUS:  s_op = OP_ADD;
            C_MINUS: s_op = OP_SUB;
            C_MUL:   s_op = OP_MUL;
            C_DIV:   s_op = OP_DIV;
            default: s_op = OP_POW;
        endcase
    end

    pee_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.start), .i_op(s_op),
        .i_lhs(r_lhs), .i_rhs(r_rhs), .o_done(s_done), .o_res(s_res),
        .o_div0(s_div0)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_top) r_rd <= r_mem[PTR_W'(r_cnt - CNT_W'(1))];
        if (s_push && !s_full) r_mem[r_cnt[PTR_W-1:0]] <= s_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_flags <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.rd_top) r_rd_ok <= (r_cnt != '0);
            if (i_cmd.clear) begin
                r_cnt   <= '0;
                r_flags <= '0;
            end else begin
                if (i_cmd.pop) begin
                    if (r_rd_ok) r_cnt <= r_cnt - CNT_W'(1);
                    else r_flags[0] <= 1'b1;
                end
                if (s_push) begin
                    if (s_full) r_flags[1] <= 1'b1;
                    else r_cnt <= r_cnt + CNT_W'(1);
                end
                if (i_cmd.push_res && s_div0) r_flags[2] <= 1'b1;
                if (i_cmd.flag_bad) r_flags[3] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_sym) begin
            r_sym  <= i_symbol;
            r_last <= i_final_symbol;
        end
        if (i_cmd.pop) begin
            if (i_cmd.sel_rhs) r_rhs <= s_pop;
            else r_lhs <= s_pop;
        end
        if (i_cmd.emit) begin
            o_value <= s_pop;
            o_flags <= {r_flags[3:1], r_flags[0] | ~r_rd_ok};
        end
    end

    assign o_sts.is_digit = (r_sym >= C_ZERO) && (r_sym <= C_NINE);
    assign o_sts.is_op    = (r_sym == C_PLUS) || (r_sym == C_MINUS) ||
                            (r_sym == C_MUL) || (r_sym == C_DIV) || (r_sym == C_POW);
    assign o_sts.last     = r_last;
    assign o_sts.alu_done = s_done;
endmodule
`default_nettype wire

@@ rtl/pee_ctrl.sv @@
// ----------------------------------------------------------------------------
// pee_ctrl
// Controller state machine sequencing pops, arithmetic, push and output.
// ----------------------------------------------------------------------------
`default_nettype none
module pee_ctrl import pee_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_stall,
    output logic      o_valid
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_RHS   = 10'b0000000100,
        S_RD2   = 10'b0000001000,
        S_LHS   = 10'b0000010000,
        S_GO    = 10'b0000100000,
        S_WAIT  = 10'b0001000000,
        S_FRD   = 10'b0010000000,
        S_FPOP  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_st;

    t_st  r_st, n_st;
    logic r_ovalid, n_ovalid;
    logic s_acc;

    assign s_acc   = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_st = r_st;
        n_ovalid = r_ovalid && i_out_stall;
        o_cmd = '0;
        unique case (r_st)
            S_IDLE: begin
                o_cmd.ld_sym = s_acc;
                if (s_acc) n_st = S_DEC;
            end
            S_DEC: begin
                if (i_sts.is_digit) begin
                    o_cmd.push_dig = 1'b1;
                    n_st = i_sts.last ? S_FRD : S_IDLE;
                end else if (i_sts.is_op) begin
                    o_cmd.rd_top = 1'b1;
                    n_st = S_RHS;
                end else begin
                    o_cmd.flag_bad = 1'b1;
                    n_st = i_sts.last ? S_FRD : S_IDLE;
                end
            end
            S_RHS: begin
                o_cmd.pop = 1'b1;
                o_cmd.sel_rhs = 1'b1;
                n_st = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_top = 1'b1;
                n_st = S_LHS;
            end
            S_LHS: begin
                o_cmd.pop = 1'b1;
                n_st = S_GO;
            end
            S_GO: begin
                // Both operands are registered now; start the ALU.
                o_cmd.start = 1'b1;
                n_st = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.alu_done) begin
                    o_cmd.push_res = 1'b1;
                    n_st = i_sts.last ? S_FRD : S_IDLE;
                end
            end
            S_FRD: begin
                o_cmd.rd_top = 1'b1;
                n_st = S_FPOP;
            end
            S_FPOP: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid = 1'b1;
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.clear = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
        end
    end
endmodule
`default_nettype wire

@@ rtl/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates postfix expressions one ASCII character per transaction.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// symbol   in         i_valid, o_stall, i_symbol, i_final_symbol
// result   out        o_valid, i_stall, o_value, o_*_seen
//
// A digit or unknown character is decoded, then pushed or flagged. An
// operator reads and pops each operand in turn from the single-port stack,
// starts the iterative ALU and pushes its result when done; divide steps
// through quotient bits and power through exponent bits, except on a zero
// divisor or negative exponent. A final character then emits the stack top.
// Reset is synchronous and active low; it clears stack count, flags, states.
// A stalled result holds in its output register; the next expression may
// proceed until its own final result meets the still waiting one.
// ----------------------------------------------------------------------------
`default_nettype none
module postfix_expression_evaluator import pee_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_symbol,
    input  wire logic        i_final_symbol,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_value,
    output logic             o_underflow_seen,
    output logic             o_overflow_seen,
    output logic             o_divide_by_zero_seen,
    output logic             o_bad_symbol_seen
);
    t_cmd        s_cmd;
    t_sts        s_sts;
    logic [31:0] s_value;
    logic [3:0]  s_flags;

    // The controller sequences each transaction; the datapath owns all data.
    pee_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_stall(i_stall), .i_sts(s_sts), .o_cmd(s_cmd),
        .o_stall(o_stall), .o_valid(o_valid)
    );

    pee_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(s_cmd), .o_sts(s_sts),
        .i_symbol(i_symbol), .i_final_symbol(i_final_symbol),
        .o_value(s_value), .o_flags(s_flags)
    );

    // Flags are packed underflow, overflow, divide by zero, bad symbol.
    assign o_value               = s_value;
    assign o_underflow_seen      = s_flags[0];
    assign o_overflow_seen       = s_flags[1];
    assign o_divide_by_zero_seen = s_flags[2];
    assign o_bad_symbol_seen     = s_flags[3];
endmodule
`default_nettype wire

@@ rtl/pee_checker.sv @@
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "postfix_expression_evaluator_defines.svh"
module pee_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_value
);
    // A result stays while stalled.
    `PEE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value), "result dropped under stall")
    // After a transaction is taken the block is busy for the next cycle.
    `PEE_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input not held off after a transaction")
    // A result never appears in the cycle after a transaction is taken while none is valid.
    `PEE_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_valid && !o_stall && !o_valid, !o_valid, "result too early")
endmodule
bind postfix_expression_evaluator pee_checker u_pee_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_value(o_value)
);
`default_nettype wire

@@ tb/sv/tb_postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking bench: directed rows and sequences, then random postfix expressions,
// all scored against a behavioral evaluator of the stack machine.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_postfix_expression_evaluator;
    timeunit 1ns;
    timeprecision 1ps;
    import pee_pkg::*;

    // Codes for the directed table: whether a row carries a typed expectation.
    localparam bit CHK_MODEL = 1'b0;
    localparam bit CHK_TYPED = 1'b1;
    localparam int LAST_WAIT = 120;  // idle margin after the last expected result

    typedef struct packed {
        logic signed [31:0] value;
        logic               under;
        logic               over;
        logic               div0;
        logic               bad;
    } t_result;

    typedef struct {
        logic [7:0] sym;
        logic       last;
        bit         typed;
        t_result    res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [7:0]        i_symbol = '0;
    logic              i_final_symbol = 1'b0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic signed [31:0] o_value;
    logic              o_underflow_seen;
    logic              o_overflow_seen;
    logic              o_divide_by_zero_seen;
    logic              o_bad_symbol_seen;

    postfix_expression_evaluator u_top (.*);

    always #2 i_clk = ~i_clk;

    // Shadow of the evaluator state.
    logic [31:0] shadow_stack [STACK_DEPTH];
    int          shadow_count;
    logic        f_under, f_over, f_div0, f_bad;
    t_result     pending_results[$];
    int          errors = 0;
    int          sent_total = 0;

    function automatic logic [31:0] shadow_pop();
        if (shadow_count == 0) begin
            f_under = 1'b1;
            return '0;
        end
        shadow_count--;
        return shadow_stack[shadow_count];
    endfunction

    function automatic void shadow_push(logic [31:0] v);
        if (shadow_count >= STACK_DEPTH) begin
            f_over = 1'b1;
        end else begin
            shadow_stack[shadow_count] = v;
            shadow_count++;
        end
    endfunction

    function automatic logic [31:0] int_power(logic [31:0] b, logic [31:0] e);
        logic [31:0] r;
        r = 32'd1;
        if (e[31]) begin
            if (b == 32'd1) return 32'd1;
            if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
            return '0;
        end
        while (e != 0) begin
            if (e[0]) r = r * b;
            b = b * b;
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic logic [31:0] trunc_divide(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        if (b == 0) begin
            f_div0 = 1'b1;
            return '0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    // Applies one symbol; returns 1 with the emitted result on a final symbol.
    function automatic bit evaluate_symbol(logic [7:0] sym, logic last, output t_result r);
        logic [31:0] lhs, rhs, res;
        r = '{default: '0};
        if (sym >= C_ZERO && sym <= C_NINE) begin
            shadow_push(32'(sym - C_ZERO));
        end else if (sym inside {C_PLUS, C_MINUS, C_MUL, C_DIV, C_POW}) begin
            rhs = shadow_pop();
            lhs = shadow_pop();
            case (sym)
                C_PLUS:  res = lhs + rhs;
                C_MINUS: res = lhs - rhs;
                C_MUL:   res = lhs * rhs;
                C_DIV:   res = trunc_divide(lhs, rhs);
                default: res = int_power(lhs, rhs);
            endcase
            shadow_push(res);
        end else begin
            f_bad = 1'b1;
        end
        if (!last) return 0;
        r.value = shadow_pop();
        r.under = f_under;
        r.over  = f_over;
        r.div0  = f_div0;
        r.bad   = f_bad;
        shadow_count = 0;
        {f_under, f_over, f_div0, f_bad} = '0;
        return 1;
    endfunction

    // Sends one transaction and, on a final symbol, records the expected result.
    task automatic send_symbol(logic [7:0] sym, logic last, bit typed, t_result typed_res);
        t_result r;
        i_valid        <= 1'b1;
        i_symbol       <= sym;
        i_final_symbol <= last;
        do @(posedge i_clk); while (o_stall);
        sent_total++;
        if (evaluate_symbol(sym, last, r)) begin
            if (typed && r != typed_res) begin
                $display("%0t table row disagrees: typed %0d, evaluator %0d",
                         $time, typed_res.value, r.value);
                errors++;
            end
            pending_results.push_back(r);
        end
        // Random gap between bursts; valid drops only when a gap follows.
        if ($urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Result checker: every accepted result meets the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_value, o_underflow_seen, o_overflow_seen,
                    o_divide_by_zero_seen, o_bad_symbol_seen};
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result value %0d", $time, got.value);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t value: expected %0d actual %0d", $time, want.value, got.value);
                    errors++;
                end
                if ({got.under, got.over, got.div0, got.bad} !==
                    {want.under, want.over, want.div0, want.bad}) begin
                    $display("%0t flags u/o/d/b: expected %b actual %b", $time,
                             {want.under, want.over, want.div0, want.bad},
                             {got.under, got.over, got.div0, got.bad});
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern: cycling through calm, lightly busy and busy stretches.
    always @(posedge i_clk) begin
        int phase;
        phase = ($time / 4000) % 3;
        if (phase == 0) i_stall <= 1'b0;
        else if (phase == 1) i_stall <= ($urandom_range(0, 3) == 0);
        else i_stall <= ($urandom_range(0, 1) == 0);
    end

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0: return C_PLUS;
            1: return C_MINUS;
            2: return C_MUL;
            3: return C_DIV;
            default: return C_POW;
        endcase
    endfunction

    function automatic logic [7:0] random_digit();
        return C_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Directed table. Typed expectations only where obvious by inspection.
    t_row directed[] = '{
        '{8'h30, 1'b1, CHK_TYPED, '{32'sd0, 0, 0, 0, 0}},   // lone zero
        '{8'h39, 1'b1, CHK_TYPED, '{32'sd9, 0, 0, 0, 0}},   // lone nine
        '{8'h2B, 1'b1, CHK_TYPED, '{32'sd0, 1, 0, 0, 0}},   // operator on empty stack
        '{8'h00, 1'b1, CHK_TYPED, '{32'sd0, 1, 0, 0, 1}},   // unknown character, empty pop
        '{8'hFF, 1'b0, CHK_MODEL, '{default: '0}},
        '{8'h35, 1'b1, CHK_TYPED, '{32'sd5, 0, 0, 0, 1}},
        '{8'h37, 1'b0, CHK_MODEL, '{default: '0}},          // 7 0 / : divide by zero
        '{8'h30, 1'b0, CHK_MODEL, '{default: '0}},
        '{8'h2F, 1'b1, CHK_TYPED, '{32'sd0, 0, 0, 1, 0}},
        '{8'h33, 1'b0, CHK_MODEL, '{default: '0}},          // 3 8 - = -5
        '{8'h38, 1'b0, CHK_MODEL, '{default: '0}},
        '{8'h2D, 1'b1, CHK_TYPED, '{-32'sd5, 0, 0, 0, 0}},
        '{8'h30, 1'b0, CHK_MODEL, '{default: '0}},          // 0 0 $ = 1
        '{8'h30, 1'b0, CHK_MODEL, '{default: '0}},
        '{8'h24, 1'b1, CHK_TYPED, '{32'sd1, 0, 0, 0, 0}},
        '{8'h36, 1'b0, CHK_MODEL, '{default: '0}},          // 6 7 * = 42
        '{8'h37, 1'b0, CHK_MODEL, '{default: '0}},
        '{8'h2A, 1'b1, CHK_TYPED, '{32'sd42, 0, 0, 0, 0}},
        '{8'h32, 1'b0, CHK_MODEL, '{default: '0}},          // 2 9 + = 11, checked by evaluator
        '{8'h39, 1'b0, CHK_MODEL, '{default: '0}},
        '{8'h2B, 1'b1, CHK_MODEL, '{default: '0}}
    };

    // Builds a value chain; with negate, the top becomes negative via 0 x -.
    task automatic push_signed(bit negate);
        send_symbol(random_digit(), 1'b0, CHK_MODEL, '{default: '0});
        if (negate) begin
            send_symbol(C_ZERO, 1'b0, CHK_MODEL, '{default: '0});
            send_symbol(C_ZERO + 8'($urandom_range(1, 9)), 1'b0, CHK_MODEL, '{default: '0});
            send_symbol(C_MINUS, 1'b0, CHK_MODEL, '{default: '0});
        end
    endtask

    initial begin
        int depth, n;
        shadow_count = 0;
        {f_under, f_over, f_div0, f_bad} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_symbol(directed[k].sym, directed[k].last, directed[k].typed, directed[k].res);

        // Overflow: 34 digits into a 32-deep stack.
        repeat (34) send_symbol(random_digit(), 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(C_PLUS, 1'b1, CHK_MODEL, '{default: '0});

        // Most negative divided by minus one: build 2^31 as 2 4 8 * 1 - $, then 0 1 - /.
        send_symbol(8'h32, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(8'h34, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(8'h38, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(C_MUL, 1'b0, CHK_MODEL, '{default: '0});   // 32
        send_symbol(8'h31, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(C_MINUS, 1'b0, CHK_MODEL, '{default: '0}); // 31
        send_symbol(C_POW, 1'b0, CHK_MODEL, '{default: '0});   // 0x80000000
        send_symbol(8'h30, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(8'h31, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(C_MINUS, 1'b0, CHK_MODEL, '{default: '0});
        send_symbol(C_DIV, 1'b1, CHK_MODEL, '{default: '0});

        // Sender holds off until every expected result has come.
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);

        // Random expressions: mostly well formed, some noise.
        while (sent_total < 1400) begin
            n = $urandom_range(1, 6);
            push_signed($urandom_range(0, 3) == 0);
            for (depth = 1; depth < n; depth++) begin
                push_signed($urandom_range(0, 4) == 0);
                send_symbol(random_operator(), 1'b0, CHK_MODEL, '{default: '0});
            end
            if ($urandom_range(0, 9) == 0)
                send_symbol(8'($urandom_range(0, 255)), 1'b0, CHK_MODEL, '{default: '0});
            if ($urandom_range(0, 9) == 0)
                send_symbol(random_operator(), 1'b0, CHK_MODEL, '{default: '0});
            if ($urandom_range(0, 1))
                send_symbol(random_operator(), 1'b1, CHK_MODEL, '{default: '0});
            else
                send_symbol(8'($urandom_range(0, 255)), 1'b1, CHK_MODEL, '{default: '0});
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LAST_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
